// ===== hdl/order_book_imbalance_ema_core_assert.svh =====
// assertion helpers for the imbalance core, sampled on clk, off while rst_n is low
`ifndef ORDER_BOOK_IMBALANCE_EMA_CORE_ASSERT_SVH
`define ORDER_BOOK_IMBALANCE_EMA_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define OBIE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define OBIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/obie_pkg.sv =====
`timescale 1ns / 1ps
package obie_pkg;

  localparam int MAX_LEVELS = 255;
  localparam int QTY_BITS   = 32;
  localparam int FRAC_BITS  = 16;

  localparam int QTY_W   = 32;
  localparam int TOT_W   = 40;
  localparam int SUM_W   = TOT_W + 1;
  localparam int REM_W   = TOT_W + 2;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int IMB_W   = 18;
  localparam int ALPHA_W = 17;
  localparam int PROD_W  = 2 * IMB_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int CNT_W   = $clog2(FRAC_BITS + 1);
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [QTY_W-1:0] QTY_MASK = (QTY_BITS >= QTY_W) ? {QTY_W{1'b1}} :
                                          QTY_W'((64'd1 << QTY_BITS) - 64'd1);
  localparam logic [TOT_W-1:0]   TOTAL_MAX = {TOT_W{1'b1}};
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [7:0]         LEVEL_CAP = 8'(MAX_LEVELS);
  localparam logic [7:0]         SEEN_MAX  = 8'd255;

  // input commands
  localparam logic [1:0] CMD_LEVEL   = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_AVG_CLR = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINVOL = 2'd2;

  localparam logic [7:0]         DEPTH_RST  = 8'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd6554;
  localparam logic [TOT_W-1:0]   MINVOL_RST = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic acc_en;      // level request taken
    logic snap_start;  // end of snapshot taken
    logic avg_clear;   // reset-average request taken
    logic div_step;
    logic mul_en;
    logic sum_en;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

// ===== hdl/order_book_imbalance_ema_core.sv =====
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | in_command, in_side, in_quantity
// out      | out_valid / out_stall| out_raw_imbalance, out_smoothed_imbalance,
//          |                      | out_significant
// cfg      | cfg_we               | cfg_index, cfg_data
// level, reset-average and unused requests are acted on as they are taken.
// an end of snapshot runs through the restoring divider (FRAC_BITS + 1 quotient
// bits), one multiply and one sum before its result is posted.
// levels are still taken while the divider runs; a further end waits for the pipe to
// finish and the result register to empty, a reset-average for the divider/ema pipe.
// reset is synchronous on rst_n low and clears totals, average and control state.
module order_book_imbalance_ema_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_command,
  input  logic                                   in_side,
  input  logic [obie_pkg::QTY_W-1:0]             in_quantity,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [obie_pkg::IMB_W-1:0]      out_raw_imbalance,
  output logic signed [obie_pkg::IMB_W-1:0]      out_smoothed_imbalance,
  output logic                                   out_significant,
  input  logic                                   cfg_we,
  input  logic [obie_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [obie_pkg::CFG_W-1:0]             cfg_data
);
  import obie_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  obie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (dp_cmd),
    .sts        (dp_sts)
  );

  obie_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (dp_cmd),
    .sts                    (dp_sts),
    .in_side                (in_side),
    .in_quantity            (in_quantity),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_raw_imbalance      (out_raw_imbalance),
    .out_smoothed_imbalance (out_smoothed_imbalance),
    .out_significant        (out_significant)
  );

endmodule

// ===== hdl/obie_datapath.sv =====
`timescale 1ns / 1ps
module obie_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  obie_pkg::dp_cmd_t                      cmd,
  output obie_pkg::dp_sts_t                      sts,
  input  logic                                   in_side,
  input  logic [obie_pkg::QTY_W-1:0]             in_quantity,
  input  logic                                   cfg_we,
  input  logic [obie_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [obie_pkg::CFG_W-1:0]             cfg_data,
  output logic signed [obie_pkg::IMB_W-1:0]      out_raw_imbalance,
  output logic signed [obie_pkg::IMB_W-1:0]      out_smoothed_imbalance,
  output logic                                   out_significant
);
  import obie_pkg::*;

  logic [7:0]         depth_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [TOT_W-1:0]   minvol_r;

  logic [TOT_W-1:0] bid_tot_r, ask_tot_r;
  logic [7:0]       bid_seen_r, ask_seen_r;
  logic signed [IMB_W-1:0] avg_r;
  logic                    loaded_r;

  logic [REM_W-1:0] rem_r;
  logic [SUM_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, zero_r, sig_r;

  logic signed [IMB_W-1:0]  raw_r;
  logic signed [PROD_W-1:0] p_new_r, p_old_r;

  logic signed [IMB_W-1:0] raw_out_r, smooth_out_r;
  logic                    sig_out_r;

  // level accumulation
  logic [TOT_W-1:0] cur_tot;
  logic [7:0]       cur_seen;
  logic [SUM_W-1:0] add_sum;
  logic [TOT_W-1:0] add_tot;
  logic             take_qty;
  logic [7:0]       seen_inc;

  always_comb begin
    cur_tot  = in_side ? ask_tot_r : bid_tot_r;
    cur_seen = in_side ? ask_seen_r : bid_seen_r;
    take_qty = (cur_seen < depth_r) && (cur_seen < LEVEL_CAP);
    add_sum  = {1'b0, cur_tot} + SUM_W'(in_quantity & QTY_MASK);
    add_tot  = add_sum[TOT_W] ? TOTAL_MAX : add_sum[TOT_W-1:0];
    if (!take_qty) begin
      add_tot = cur_tot;
    end
    seen_inc = (cur_seen == SEEN_MAX) ? cur_seen : cur_seen + 8'd1;
  end

  // snapshot end: operands for the divider
  logic [SUM_W-1:0] total;
  logic [TOT_W-1:0] diff;
  always_comb begin
    total = {1'b0, bid_tot_r} + {1'b0, ask_tot_r};
    diff  = (bid_tot_r >= ask_tot_r) ? bid_tot_r - ask_tot_r : ask_tot_r - bid_tot_r;
  end

  // restoring divider step, one quotient bit a cycle
  logic             ge;
  logic [REM_W-1:0] rem_sub;
  always_comb begin
    ge      = rem_r >= REM_W'(den_r);
    rem_sub = ge ? rem_r - REM_W'(den_r) : rem_r;
  end

  // ema products
  logic [ALPHA_W-1:0]      alpha_eff;
  logic signed [IMB_W-1:0] raw_c;
  always_comb begin
    alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    raw_c     = signed'(IMB_W'(quo_r));
    if (zero_r) begin
      raw_c = '0;
    end else if (neg_r) begin
      raw_c = -signed'(IMB_W'(quo_r));
    end
  end

  logic signed [ACC_W-1:0] ema_sum;
  logic signed [ACC_W-1:0] ema_shift;
  always_comb begin
    ema_sum   = ACC_W'(p_new_r) + ACC_W'(p_old_r);
    ema_shift = ema_sum >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= DEPTH_RST;
      alpha_r    <= ALPHA_RST;
      minvol_r   <= MINVOL_RST;
      bid_tot_r  <= '0;
      ask_tot_r  <= '0;
      bid_seen_r <= '0;
      ask_seen_r <= '0;
      avg_r      <= '0;
      loaded_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH:  depth_r  <= cfg_data[7:0];
          REG_ALPHA:  alpha_r  <= cfg_data[ALPHA_W-1:0];
          REG_MINVOL: minvol_r <= cfg_data[TOT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.acc_en) begin
        if (in_side) begin
          ask_tot_r  <= add_tot;
          ask_seen_r <= seen_inc;
        end else begin
          bid_tot_r  <= add_tot;
          bid_seen_r <= seen_inc;
        end
      end
      if (cmd.snap_start) begin
        bid_tot_r  <= '0;
        ask_tot_r  <= '0;
        bid_seen_r <= '0;
        ask_seen_r <= '0;
      end
      if (cmd.avg_clear) begin
        avg_r    <= '0;
        loaded_r <= 1'b0;
      end
      if (cmd.sum_en) begin
        avg_r    <= loaded_r ? ema_shift[IMB_W-1:0] : raw_r;
        loaded_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_start) begin
      rem_r  <= REM_W'(diff);
      den_r  <= total;
      quo_r  <= '0;
      cnt_r  <= CNT_W'(FRAC_BITS);
      neg_r  <= bid_tot_r < ask_tot_r;
      zero_r <= (bid_seen_r == '0) || (ask_seen_r == '0) || (total == '0);
      sig_r  <= total >= SUM_W'(minvol_r);
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[REM_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.mul_en) begin
      raw_r   <= raw_c;
      p_new_r <= raw_c * signed'({1'b0, alpha_eff});
      p_old_r <= avg_r * signed'({1'b0, ALPHA_ONE - alpha_eff});
    end
    if (cmd.sum_en) begin
      raw_out_r    <= raw_r;
      smooth_out_r <= loaded_r ? ema_shift[IMB_W-1:0] : raw_r;
      sig_out_r    <= sig_r;
    end
  end

  assign sts.div_last           = (cnt_r == '0);
  assign out_raw_imbalance      = raw_out_r;
  assign out_smoothed_imbalance = smooth_out_r;
  assign out_significant        = sig_out_r;

endmodule

// ===== hdl/obie_ctrl.sv =====
`timescale 1ns / 1ps
`include "order_book_imbalance_ema_core_assert.svh"
module obie_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output obie_pkg::dp_cmd_t cmd,
  input  obie_pkg::dp_sts_t sts
);
  import obie_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   busy, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
    // levels keep flowing while the divider runs; end and average reset wait
    case (in_command)
      CMD_END:     in_stall = busy || out_valid_r;
      CMD_AVG_CLR: in_stall = busy;
      default:     in_stall = 1'b0;
    endcase
    take = in_valid && !in_stall;

    cmd            = '0;
    cmd.acc_en     = take && (in_command == CMD_LEVEL);
    cmd.snap_start = take && (in_command == CMD_END);
    cmd.avg_clear  = take && (in_command == CMD_AVG_CLR);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.snap_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `OBIE_ASSERT_SAME(a_end_when_free, cmd.snap_start, (state_r == ST_IDLE) && !out_valid_r, "end request taken while busy or result pending")
  `OBIE_ASSERT_NEXT(a_sum_gives_result, state_r == ST_SUM, out_valid_r && (state_r == ST_IDLE), "result not posted after sum")
  `OBIE_ASSERT_NEXT(a_div_leaves, (state_r == ST_DIV) && sts.div_last, state_r == ST_MUL, "divider did not hand over to multiply")
  `OBIE_ASSERT_SAME(a_one_phase, 1'b1, $onehot0({cmd.snap_start, cmd.avg_clear, cmd.mul_en, cmd.sum_en}), "overlapping datapath phases")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import obie_pkg::*;

  localparam int RANDOM_REQS    = 280;
  localparam int SETTLE_CYCLES  = FRAC_BITS + 3 + 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int ALPHA_SHIFT    = 16;

  typedef struct packed {
    logic signed [IMB_W-1:0] raw;
    logic signed [IMB_W-1:0] smooth;
    logic                    sig;
  } imb_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_command;
  logic                      in_side;
  logic [QTY_W-1:0]          in_quantity;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [IMB_W-1:0]   out_raw_imbalance;
  logic signed [IMB_W-1:0]   out_smoothed_imbalance;
  logic                      out_significant;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  // predictor copy of the block's registers and book state
  logic [7:0]         depth_cfg  = DEPTH_RST;
  logic [ALPHA_W-1:0] alpha_cfg  = ALPHA_RST;
  logic [TOT_W-1:0]   minvol_cfg = MINVOL_RST;
  logic [TOT_W-1:0]   bid_acc    = '0;
  logic [TOT_W-1:0]   ask_acc    = '0;
  logic [7:0]         bid_lvls   = '0;
  logic [7:0]         ask_lvls   = '0;
  longint             ema_val    = 0;
  logic               ema_primed = 1'b0;

  imb_result_t imb_expect_q[$];

  int  err_count    = 0;
  int  reqs_done    = 0;
  int  hold_req     = 0;
  int  idle_cycles  = 0;
  bit  src_idle_en  = 1'b1;
  bit  sink_idle_en = 1'b1;

  always #2 clk = ~clk;

  order_book_imbalance_ema_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_side                (in_side),
    .in_quantity            (in_quantity),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_raw_imbalance      (out_raw_imbalance),
    .out_smoothed_imbalance (out_smoothed_imbalance),
    .out_significant        (out_significant),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [QTY_W-1:0] rand_qty();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 80) return $urandom_range(0, 255);
    if (r < 90) return '0;
    return '1;
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] acc,
                                               input logic [QTY_W-1:0] qty);
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(qty & QTY_MASK);
    return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOT_W-1:0];
  endfunction

  // advance the book state by one accepted request, queue the snapshot result
  function automatic void book_update(input logic [1:0] cmd, input logic side,
                                      input logic [QTY_W-1:0] qty);
    logic [SUM_W-1:0] vol;
    logic [TOT_W-1:0] diff;
    logic [63:0]      quo;
    longint           raw;
    longint           a;
    longint           mix;
    imb_result_t      res;
    case (cmd)
      CMD_LEVEL: begin
        if (!side) begin
          if (bid_lvls < depth_cfg && bid_lvls < LEVEL_CAP) bid_acc = sat_add(bid_acc, qty);
          if (bid_lvls != SEEN_MAX) bid_lvls++;
        end else begin
          if (ask_lvls < depth_cfg && ask_lvls < LEVEL_CAP) ask_acc = sat_add(ask_acc, qty);
          if (ask_lvls != SEEN_MAX) ask_lvls++;
        end
      end
      CMD_AVG_CLR: begin
        ema_val = 0;
        ema_primed = 1'b0;
      end
      CMD_END: begin
        vol = SUM_W'(bid_acc) + SUM_W'(ask_acc);
        raw = 0;
        if (bid_lvls != 0 && ask_lvls != 0 && vol != 0) begin
          diff = (bid_acc >= ask_acc) ? bid_acc - ask_acc : ask_acc - bid_acc;
          // truncating division of the magnitude gives rounding toward zero
          quo = (64'(diff) << FRAC_BITS) / 64'(vol);
          raw = (bid_acc >= ask_acc) ? longint'(quo) : -longint'(quo);
        end
        a = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
        if (!ema_primed) begin
          ema_val = raw;
          ema_primed = 1'b1;
        end else begin
          mix = a * raw + (longint'(ALPHA_ONE) - a) * ema_val;
          ema_val = mix >>> ALPHA_SHIFT;
        end
        res.raw    = raw[IMB_W-1:0];
        res.smooth = ema_val[IMB_W-1:0];
        res.sig    = (vol >= SUM_W'(minvol_cfg));
        imb_expect_q.push_back(res);
        bid_acc  = '0;
        ask_acc  = '0;
        bid_lvls = '0;
        ask_lvls = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [1:0] cmd, input logic side,
                          input logic [QTY_W-1:0] qty);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_side     <= side;
    in_quantity <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book_update(cmd, side, qty);
    if (cmd != CMD_NONE) reqs_done++;
  endtask

  task automatic send_snapshot(input int n_levels, input int ask_pct);
    for (int i = 0; i < n_levels; i++)
      send_req(CMD_LEVEL, $urandom_range(0, 99) < ask_pct, rand_qty());
    send_req(CMD_END, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // let the block go quiet: nothing expected and the pipe past its latency
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (imb_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPTH:  depth_cfg  = val[7:0];
      REG_ALPHA:  alpha_cfg  = val[ALPHA_W-1:0];
      REG_MINVOL: minvol_cfg = val[TOT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_book_cfg(input logic [7:0] depth, input logic [ALPHA_W-1:0] alpha,
                              input logic [TOT_W-1:0] minvol);
    drain_results();
    write_reg(REG_DEPTH, CFG_W'(depth));
    write_reg(REG_ALPHA, CFG_W'(alpha));
    write_reg(REG_MINVOL, CFG_W'(minvol));
  endtask

  task automatic test_directed();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // empty book
    send_req(CMD_END, 1'b1, '1);
    // ask side empty
    send_req(CMD_LEVEL, 1'b0, 32'd100);
    send_req(CMD_END, 1'b0, '0);
    // bid side empty
    send_req(CMD_LEVEL, 1'b1, '1);
    send_req(CMD_END, 1'b0, '0);
    // both sides present, zero volume
    send_req(CMD_LEVEL, 1'b0, '0);
    send_req(CMD_LEVEL, 1'b1, '0);
    send_req(CMD_END, 1'b1, '0);
    // all bid, then all ask
    send_req(CMD_LEVEL, 1'b0, '1);
    send_req(CMD_LEVEL, 1'b1, '0);
    send_req(CMD_END, 1'b0, '1);
    send_req(CMD_LEVEL, 1'b1, '1);
    send_req(CMD_LEVEL, 1'b0, '0);
    send_req(CMD_END, 1'b1, '1);
    send_req(CMD_LEVEL, 1'b0, 32'd1);
    send_req(CMD_LEVEL, 1'b1, 32'd3);
    send_req(CMD_END, 1'b0, '0);
    // unused command, then average cleared mid snapshot
    send_req(CMD_NONE, 1'b1, '1);
    send_req(CMD_LEVEL, 1'b0, 32'd7);
    send_req(CMD_AVG_CLR, 1'b0, '0);
    send_req(CMD_LEVEL, 1'b1, 32'd2);
    send_req(CMD_END, 1'b1, '0);
  endtask

  task automatic test_config_sweep();
    // depth zero: nothing summed
    set_book_cfg(8'd0, 17'd32768, '0);
    send_req(CMD_LEVEL, 1'b0, 32'd5);
    send_req(CMD_LEVEL, 1'b1, 32'd9);
    send_req(CMD_END, 1'b0, '0);
    repeat (2) send_snapshot($urandom_range(0, 8), 50);

    // one level per side, levels past depth ignored, significance boundary
    set_book_cfg(8'd1, ALPHA_ONE, 40'd1000);
    send_req(CMD_LEVEL, 1'b0, 32'd600);
    send_req(CMD_LEVEL, 1'b0, 32'd999999);
    send_req(CMD_LEVEL, 1'b1, 32'd400);
    send_req(CMD_LEVEL, 1'b1, 32'd7);
    send_req(CMD_END, 1'b0, '0);
    send_req(CMD_LEVEL, 1'b1, 32'd399);
    send_req(CMD_LEVEL, 1'b0, 32'd600);
    send_req(CMD_END, 1'b1, '0);
    repeat (2) send_snapshot($urandom_range(0, 8), 50);

    // full depth, alpha above one, volume never enough; level count saturates
    set_book_cfg(8'd255, 17'h1FFFF, TOTAL_MAX);
    repeat (300) send_req(CMD_LEVEL, 1'b0, '1);
    send_req(CMD_LEVEL, 1'b1, $urandom);
    send_req(CMD_END, 1'b0, '0);
    repeat (2) send_snapshot($urandom_range(0, 12), 50);

    // alpha zero holds the average
    set_book_cfg(8'd7, '0, 40'h2_0000_0000);
    repeat (3) send_snapshot($urandom_range(2, 12), 50);

    set_book_cfg(8'd10, 17'd1, 40'd1);
    send_req(CMD_AVG_CLR, 1'b1, '1);
    repeat (3) send_snapshot($urandom_range(0, 12), 50);
  endtask

  task automatic test_random();
    int          base;
    int          next_cfg;
    int          r;
    int          n;
    int          pct;
    logic [7:0]  depth;
    logic [ALPHA_W-1:0] alpha;
    logic [63:0] w;
    base = reqs_done;
    next_cfg = 0;
    while (reqs_done - base < RANDOM_REQS) begin
      if (reqs_done - base >= next_cfg) begin
        r = $urandom_range(0, 99);
        depth = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(1, 16));
        r = $urandom_range(0, 99);
        if (r < 10) alpha = ALPHA_W'($urandom_range(65537, 131071));
        else if (r < 15) alpha = '0;
        else if (r < 20) alpha = ALPHA_ONE;
        else alpha = ALPHA_W'($urandom_range(1, 65535));
        w = {$urandom, $urandom};
        set_book_cfg(depth, alpha, w[TOT_W-1:0] >> $urandom_range(0, 40));
        next_cfg += 120 + $urandom_range(0, 60);
      end
      src_idle_en  = $urandom_range(0, 99) < 80;
      sink_idle_en = $urandom_range(0, 99) < 80;
      r = $urandom_range(0, 99);
      if (r < 84) begin
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 16) : $urandom_range(17, 40);
        r = $urandom_range(0, 99);
        pct = (r < 8) ? 0 : (r < 16) ? 100 : $urandom_range(20, 80);
        send_snapshot(n, pct);
      end else if (r < 89) begin
        send_req(CMD_AVG_CLR, 1'($urandom_range(0, 1)), $urandom);
      end else if (r < 94) begin
        send_req(CMD_NONE, 1'($urandom_range(0, 1)), $urandom);
      end else if (r < 97) begin
        // snapshot broken off: its levels run into the next one
        repeat ($urandom_range(1, 5))
          send_req(CMD_LEVEL, 1'($urandom_range(0, 1)), rand_qty());
      end else begin
        send_req(CMD_END, 1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (8) send_snapshot(4, 50);
    drain_results();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (3) send_snapshot($urandom_range(1, 10), 50);
  endtask

  // result side stall pattern, plus the long hold-off on request
  initial begin : sink_drive
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req > 0) begin
        stall_left = hold_req - 1;
        hold_req = 0;
        out_stall <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    imb_result_t got;
    imb_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.raw    = out_raw_imbalance;
      got.smooth = out_smoothed_imbalance;
      got.sig    = out_significant;
      if (imb_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: raw %0d smooth %0d sig %0b",
                   got.raw, got.smooth, got.sig);
      end else begin
        want = imb_expect_q.pop_front();
        if (got.raw !== want.raw || got.smooth !== want.smooth || got.sig !== want.sig) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: raw exp %0d got %0d, smooth exp %0d got %0d, sig exp %0b got %0b",
                     want.raw, got.raw, want.smooth, got.smooth, want.sig, got.sig);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    in_valid    = 1'b0;
    in_command  = CMD_NONE;
    in_side     = 1'b0;
    in_quantity = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_DEPTH;
    cfg_data    = '0;
    rst_n       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    drain_results();
    if (imb_expect_q.size() != 0) err_count += imb_expect_q.size();
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
